// ----- rtl/ecf_pkg.sv -----
package ecf_pkg;

	// Fixed field and register widths.
	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 17;
	localparam int COEF_W   = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DELAY_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORM  = 2'd3;

	// Mode codes.
	localparam logic MODE_FEEDFWD  = 1'b0;
	localparam logic MODE_FEEDBACK = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [DELAY_W-1:0] DELAY_RST = 17'd100000;
	localparam logic [COEF_W-1:0]  GAIN_RST  = 15'd29491;
	localparam logic [COEF_W-1:0]  NORM_RST  = 15'd17246;

	// Sample sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL_GAIN,
		ST_MUL_NORM,
		ST_DONE
	} seq_state_t;

	// Clamp an 18-bit signed value to the signed 16-bit range.
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/ecf_in_if.sv -----
interface ecf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ecf_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- rtl/ecf_out_if.sv -----
interface ecf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ecf_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/echo_comb_filter_top.sv -----
// Echo comb filter for a stream of signed 16-bit audio samples.
// Samples enter on in_stream and echoed samples leave on out_stream; both are
// valid/ready channels, and every input transaction yields exactly one output
// transaction, in order. Mode 0 is a normalized feedforward echo, mode 1 a
// feedback echo with saturation. Mode, delay, gain and norm are set through the
// plain write port (cfg_wr_en, cfg_index, cfg_wdata); the user must write them
// only while the block is idle, which the block itself does not enforce.
// Each sample goes through these steps in order: the accept cycle issues the
// delay RAM read, then the gain multiply, then the add and norm multiply, then
// saturation with write-back into the delay RAM. A new sample is accepted only
// once the previous one has left its last step.
// The result sits in an output register, so the next sample is accepted while
// it waits. If the receiver stalls and the output register is still full when
// the next result is ready, the sequencer holds in its last step until the
// register frees up; input is not taken meanwhile.
// Reset (arst_n low) restores the register defaults and empties the delay line
// logically: a fill flag marks the RAM as not yet wrapped, and entries not yet
// written read as zero, so no clearing pass is needed.
module echo_comb_filter_top #(
	parameter int DELAY_DEPTH = 131072
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ecf_in_if.sink                          in_stream,
	ecf_out_if.source                       out_stream,
	input  logic                            cfg_wr_en,
	input  logic [ecf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ecf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int CW = (AW > ecf_pkg::DELAY_W) ? AW : ecf_pkg::DELAY_W;
	localparam logic [CW-1:0] DLY_MAX   = CW'(DELAY_DEPTH - 1);
	localparam logic [AW-1:0] WP_LAST   = AW'(DELAY_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DELAY_DEPTH);

	// Configuration registers.
	logic                           mode_q;
	logic [ecf_pkg::DELAY_W-1:0]    delay_q;
	logic [ecf_pkg::COEF_W-1:0]     gain_q;
	logic [ecf_pkg::COEF_W-1:0]     norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ecf_pkg::MODE_FEEDFWD;
			delay_q <= ecf_pkg::DELAY_RST;
			gain_q  <= ecf_pkg::GAIN_RST;
			norm_q  <= ecf_pkg::NORM_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ecf_pkg::REG_MODE:  mode_q  <= cfg_wdata[0];
				ecf_pkg::REG_DELAY: delay_q <= cfg_wdata[ecf_pkg::DELAY_W-1:0];
				ecf_pkg::REG_GAIN:  gain_q  <= cfg_wdata[ecf_pkg::COEF_W-1:0];
				ecf_pkg::REG_NORM:  norm_q  <= cfg_wdata[ecf_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state and handshake controls.
	ecf_pkg::seq_state_t state_q, state_nxt;
	logic accept;
	logic out_free;
	logic finish;
	logic out_valid_q;

	assign out_free = !out_valid_q || out_stream.ready;
	assign accept   = in_stream.valid && in_stream.ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ecf_pkg::ST_IDLE:     if (in_stream.valid) state_nxt = ecf_pkg::ST_MUL_GAIN;
			ecf_pkg::ST_MUL_GAIN: state_nxt = ecf_pkg::ST_MUL_NORM;
			ecf_pkg::ST_MUL_NORM: state_nxt = ecf_pkg::ST_DONE;
			ecf_pkg::ST_DONE:     if (out_free) state_nxt = ecf_pkg::ST_IDLE;
			default:              state_nxt = ecf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stream.ready = (state_q == ecf_pkg::ST_IDLE);
		finish          = (state_q == ecf_pkg::ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Effective delay: zero acts as one, values past the line clamp to its end.
	logic [CW-1:0] dly_ext;
	logic [CW-1:0] dly_clamped;
	logic [AW-1:0] dly_eff;

	always_comb begin
		dly_ext = CW'(delay_q);
		if (delay_q == '0) begin
			dly_clamped = CW'(1);
		end else if (dly_ext > DLY_MAX) begin
			dly_clamped = DLY_MAX;
		end else begin
			dly_clamped = dly_ext;
		end
		dly_eff = dly_clamped[AW-1:0];
	end

	// Write pointer and fill flag. Until the pointer first wraps, an entry
	// behind the pointer by more than its value was never written and reads as zero.
	logic [AW-1:0] wp_q;
	logic          full_q;
	logic [AW:0]   rp_wrap;
	logic [AW-1:0] rp;
	logic          no_wrap;
	logic          past_hit;

	always_comb begin
		no_wrap  = (wp_q >= dly_eff);
		rp_wrap  = {1'b0, wp_q} + DEPTH_EXT - {1'b0, dly_eff};
		rp       = no_wrap ? (wp_q - dly_eff) : rp_wrap[AW-1:0];
		past_hit = full_q || no_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (finish) begin
			if (wp_q == WP_LAST) begin
				wp_q   <= '0;
				full_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

	// Delay line storage.
	logic                                ram_we;
	logic signed [ecf_pkg::SAMPLE_W-1:0] ram_wdata;
	logic        [ecf_pkg::SAMPLE_W-1:0] ram_rdata;

	ecf_delay_ram #(
		.DEPTH (DELAY_DEPTH),
		.AW    (AW),
		.W     (ecf_pkg::SAMPLE_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (rp),
		.rdata (ram_rdata)
	);

	// Captured input sample and whether the delayed entry holds real data.
	logic signed [ecf_pkg::SAMPLE_W-1:0] x_q;
	logic                                hit_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= in_stream.sample_in;
			hit_q <= past_hit;
		end
	end

	// Gain multiply: past sample times unsigned Q15 gain.
	logic signed [ecf_pkg::SAMPLE_W-1:0] past;
	logic signed [31:0]                  prod_gain_s1;

	assign past = hit_q ? $signed(ram_rdata) : '0;

	always_ff @(posedge clk) begin
		if (state_q == ecf_pkg::ST_MUL_GAIN) begin
			prod_gain_s1 <= past * $signed({1'b0, gain_q});
		end
	end

	// Truncate toward zero, add the input, then scale by norm for mode 0.
	// Mode 1 saturates the sum directly.
	logic signed [31:0]                  gain_bias;
	logic signed [16:0]                  echo_term;
	logic signed [16:0]                  echo_sum;
	logic signed [32:0]                  prod_norm_s2;
	logic signed [ecf_pkg::SAMPLE_W-1:0] fb_sat_s2;

	always_comb begin
		gain_bias = prod_gain_s1 + (prod_gain_s1[31] ? 32'sd32767 : 32'sd0);
		echo_term = 17'(gain_bias >>> 15);
		echo_sum  = 17'(x_q) + echo_term;
	end

	always_ff @(posedge clk) begin
		if (state_q == ecf_pkg::ST_MUL_NORM) begin
			prod_norm_s2 <= echo_sum * $signed({1'b0, norm_q});
			fb_sat_s2    <= ecf_pkg::sat16(18'(echo_sum));
		end
	end

	// Final result and delay line write-back value.
	logic signed [32:0]                  norm_bias;
	logic signed [17:0]                  ff_scaled;
	logic signed [ecf_pkg::SAMPLE_W-1:0] y;

	always_comb begin
		norm_bias = prod_norm_s2 + (prod_norm_s2[32] ? 33'sd32767 : 33'sd0);
		ff_scaled = 18'(norm_bias >>> 15);
		if (mode_q == ecf_pkg::MODE_FEEDBACK) begin
			y         = fb_sat_s2;
			ram_wdata = fb_sat_s2;
		end else begin
			y         = ecf_pkg::sat16(ff_scaled);
			ram_wdata = x_q;
		end
		ram_we = finish;
	end

	// Output register.
	logic signed [ecf_pkg::SAMPLE_W-1:0] sample_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sample_out_q <= y;
		end
	end

	assign out_stream.valid      = out_valid_q;
	assign out_stream.sample_out = sample_out_q;

endmodule

// ----- rtl/ecf_delay_ram.sv -----
// Simple dual-port delay RAM: one write port, one read port, registered read data.
module ecf_delay_ram #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17,
	parameter int W     = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- tb/sv/echo_comb_filter_checker.sv -----
module echo_comb_filter_checker #(
	parameter int DELAY_DEPTH = 131072
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ecf_in_if                              in_mon,
	ecf_out_if                             out_mon,
	input  logic                           cfg_wr_en,
	input  logic [ecf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ecf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int unsigned                    mismatches,
	output int unsigned                    pending,
	output int unsigned                    checked
);

	// Shadow copy of the configuration and of the echo memory.
	logic                                mode_q;
	logic [ecf_pkg::DELAY_W-1:0]         delay_q;
	logic [ecf_pkg::COEF_W-1:0]          gain_q;
	logic [ecf_pkg::COEF_W-1:0]          norm_q;
	logic signed [ecf_pkg::SAMPLE_W-1:0] history [DELAY_DEPTH];
	int unsigned                         head;
	logic signed [ecf_pkg::SAMPLE_W-1:0] echo_expected [$];

	// Q15 product, truncated toward zero.
	function automatic longint q15_scale(longint a, longint b);
		return (a * b) / 32768;
	endfunction

	function automatic logic signed [ecf_pkg::SAMPLE_W-1:0] clamp16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[ecf_pkg::SAMPLE_W-1:0];
	endfunction

	// Works out the echoed sample for one input sample and advances the memory.
	function automatic logic signed [ecf_pkg::SAMPLE_W-1:0] echo_of(
			logic signed [ecf_pkg::SAMPLE_W-1:0] x);
		int unsigned lag;
		int unsigned tap_idx;
		longint      tap;
		longint      y;
		lag = (delay_q == '0) ? 1 : delay_q;
		if (lag > DELAY_DEPTH - 1) lag = DELAY_DEPTH - 1;
		tap_idx = (head + DELAY_DEPTH - lag) % DELAY_DEPTH;
		tap = history[tap_idx];
		if (mode_q == ecf_pkg::MODE_FEEDFWD) begin
			y = q15_scale(x + q15_scale(tap, gain_q), norm_q);
			history[head] = x;
		end else begin
			y = x + q15_scale(tap, gain_q);
			history[head] = clamp16(y);
		end
		head = (head + 1) % DELAY_DEPTH;
		return clamp16(y);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  = ecf_pkg::MODE_FEEDFWD;
			delay_q = ecf_pkg::DELAY_RST;
			gain_q  = ecf_pkg::GAIN_RST;
			norm_q  = ecf_pkg::NORM_RST;
			head    = 0;
			foreach (history[i]) history[i] = '0;
			echo_expected.delete();
			mismatches = 0;
			checked    = 0;
			pending    = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ecf_pkg::REG_MODE:  mode_q  = cfg_wdata[0];
					ecf_pkg::REG_DELAY: delay_q = cfg_wdata[ecf_pkg::DELAY_W-1:0];
					ecf_pkg::REG_GAIN:  gain_q  = cfg_wdata[ecf_pkg::COEF_W-1:0];
					ecf_pkg::REG_NORM:  norm_q  = cfg_wdata[ecf_pkg::COEF_W-1:0];
					default: ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				if (echo_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("sample_out %0d arrived with no input sample waiting",
							out_mon.sample_out);
					end
				end else begin
					logic signed [ecf_pkg::SAMPLE_W-1:0] want;
					want = echo_expected.pop_front();
					if (out_mon.sample_out !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("sample_out mismatch at output %0d: expected %0d, got %0d",
								checked, want, out_mon.sample_out);
						end
					end
				end
				checked++;
			end
			if (in_mon.valid && in_mon.ready) begin
				echo_expected.insert(echo_expected.size(), echo_of(in_mon.sample_in));
			end
			pending = echo_expected.size();
		end
	end

endmodule

// ----- tb/sv/echo_comb_filter_top_tb.sv -----
module echo_comb_filter_top_tb;

	localparam int DEPTH = 131072;
	// Cycles with no transaction of any kind before the run is declared hung. Each
	// sample's steps in the block and the random stalls are short, so this is many
	// times the longest quiet stretch of a correct run.
	localparam int QUIET_LIMIT = 2000;
	// Cycles allowed after the last result before the block counts as idle.
	localparam int SETTLE = 8;
	localparam int PHASES = 14;
	localparam int PHASE_SAMPLES = 125;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [ecf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ecf_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                           tx_valid;
	logic signed [ecf_pkg::SAMPLE_W-1:0] tx_sample;
	logic                           rx_ready = 1'b0;
	logic                           gaps_on;
	int unsigned                    mismatches;
	int unsigned                    pending;
	int unsigned                    checked;
	int unsigned                    quiet_cycles = 0;
	int unsigned                    settings_used = 0;

	ecf_in_if  in_ch ();
	ecf_out_if out_ch ();

	// The channel signals that the testbench owns are driven from plain variables,
	// so each has exactly one driver.
	assign in_ch.valid     = tx_valid;
	assign in_ch.sample_in = tx_sample;
	assign out_ch.ready    = rx_ready;

	echo_comb_filter_top #(
		.DELAY_DEPTH(DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_stream (in_ch),
		.out_stream(out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// The checker follows every transaction and register write on its own and
	// reports back how many samples went wrong and how many are still due.
	echo_comb_filter_checker #(
		.DELAY_DEPTH(DEPTH)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_mon    (in_ch),
		.out_mon   (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.mismatches(mismatches),
		.pending   (pending),
		.checked   (checked)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The receiver stalls in about a third of the cycles while gaps are enabled
	// and is always ready otherwise.
	always @(negedge clk) begin
		rx_ready <= !gaps_on || ($urandom_range(99) >= 32);
	end

	// Any transaction or register write shows the block is alive. A long stretch
	// with none of them means the block has hung.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("echo_comb_filter_top_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one sample and returns at the falling edge after the transaction.
	// The task is entered at a falling edge; while gaps are enabled it first
	// leaves valid low for a random number of cycles.
	task automatic push_sample(input logic signed [ecf_pkg::SAMPLE_W-1:0] s);
		while (gaps_on && $urandom_range(99) < 32) begin
			tx_valid <= 1'b0;
			@(negedge clk);
		end
		tx_valid  <= 1'b1;
		tx_sample <= s;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering samples and waits until every result has come back and the
	// pipeline has had time to empty.
	task automatic drain();
		tx_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Writes all four registers once the block is idle. The unused upper bits of
	// the write data carry random junk, which the block has to ignore.
	task automatic apply_settings(input logic mode_v, input int unsigned delay_v,
			input int unsigned gain_v, input int unsigned norm_v);
		logic [ecf_pkg::CFG_DATA_W-1:0] junk;
		drain();
		junk = ecf_pkg::CFG_DATA_W'($urandom);
		cfg_wr_en <= 1'b1;
		cfg_index <= ecf_pkg::REG_MODE;
		cfg_wdata <= {junk[ecf_pkg::CFG_DATA_W-1:1], mode_v};
		@(negedge clk);
		cfg_index <= ecf_pkg::REG_DELAY;
		cfg_wdata <= ecf_pkg::CFG_DATA_W'(delay_v);
		@(negedge clk);
		junk = ecf_pkg::CFG_DATA_W'($urandom);
		cfg_index <= ecf_pkg::REG_GAIN;
		cfg_wdata <= {junk[ecf_pkg::CFG_DATA_W-1:ecf_pkg::COEF_W],
			ecf_pkg::COEF_W'(gain_v)};
		@(negedge clk);
		junk = ecf_pkg::CFG_DATA_W'($urandom);
		cfg_index <= ecf_pkg::REG_NORM;
		cfg_wdata <= {junk[ecf_pkg::CFG_DATA_W-1:ecf_pkg::COEF_W],
			ecf_pkg::COEF_W'(norm_v)};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Mostly full-range samples, with a share of full-scale values and of small
	// values whose echoes stay away from saturation.
	function automatic logic signed [ecf_pkg::SAMPLE_W-1:0] pick_sample();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4) return 16'sh7FFF;
		if (roll < 8) return 16'sh8000;
		if (roll < 10) return '0;
		if (roll < 40) return ecf_pkg::SAMPLE_W'($urandom_range(4095)) - 16'sd2048;
		return ecf_pkg::SAMPLE_W'($urandom);
	endfunction

	initial begin
		int unsigned lag;
		int unsigned gain_v;
		int unsigned norm_v;
		tx_valid  = 1'b0;
		tx_sample = '0;
		cfg_wr_en = 1'b0;
		cfg_index = ecf_pkg::REG_MODE;
		cfg_wdata = '0;
		gaps_on   = 1'b1;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A few samples with the registers at their reset values: the long default
		// delay means the echo reads from the cleared part of the memory.
		push_sample(16'sh7FFF);
		push_sample(16'sh8000);
		push_sample(16'sd1234);
		push_sample(-16'sd1);

		// Feedforward with full gain and full norm on a one-sample delay: the sum
		// of a sample and its echo overflows 16 bits and must saturate both ways.
		apply_settings(ecf_pkg::MODE_FEEDFWD, 1, 32767, 32767);
		push_sample(16'sh7FFF);
		push_sample(16'sh7FFF);
		push_sample(16'sh8000);
		push_sample(16'sh8000);
		push_sample(16'sd0);
		push_sample(-16'sd1);

		// Feedback with a delay of zero, which the block treats as one. Full-scale
		// input with full gain drives the loop into both saturation limits, and the
		// switch of mode reads what the feedforward phase left in the memory.
		apply_settings(ecf_pkg::MODE_FEEDBACK, 0, 32767, 0);
		repeat (4) push_sample(16'sh7FFF);
		repeat (4) push_sample(16'sh8000);

		// Longest delay with zero gain and zero norm: every output must be zero.
		apply_settings(ecf_pkg::MODE_FEEDFWD, 131071, 0, 0);
		push_sample(16'sh7FFF);
		push_sample(16'sh8000);
		push_sample(16'sh5555);

		// Random phases. Modes alternate without a reset, so each phase starts on
		// whatever the previous one wrote into the memory. Two phases in the middle
		// run with neither side idling.
		for (int p = 0; p < PHASES; p++) begin
			case (p % 7)
				0:       lag = 0;
				1:       lag = 1;
				2:       lag = $urandom_range(16, 2);
				3:       lag = $urandom_range(120, 17);
				4:       lag = (p < 7) ? 131071 : $urandom_range(1500, 200);
				5:       lag = $urandom_range(60, 1);
				default: lag = $urandom_range(125, 60);
			endcase
			if (p % 5 == 0) begin
				gain_v = 32767;
			end else if (p == 3) begin
				gain_v = 0;
			end else begin
				gain_v = $urandom_range(32767);
			end
			if (p % 3 == 0) begin
				norm_v = 32767;
			end else if (p == 8) begin
				norm_v = 0;
			end else begin
				norm_v = $urandom_range(32767, 8000);
			end
			gaps_on <= !(p == 6 || p == 7);
			apply_settings((p % 2 == 1) ? ecf_pkg::MODE_FEEDBACK : ecf_pkg::MODE_FEEDFWD,
				lag, gain_v, norm_v);
			repeat (PHASE_SAMPLES) push_sample(pick_sample());
		end

		drain();
		repeat (SETTLE) @(negedge clk);
		$display("Run covered %0d echoed samples under %0d register settings,", checked,
			settings_used + 1);
		$display("both modes, delays from zero to the longest, gain and norm at both ends.");
		if (mismatches == 0 && pending == 0) begin
			$display("echo_comb_filter_top_tb OK");
		end else begin
			$display("echo_comb_filter_top_tb NOT OK");
		end
		$finish;
	end

endmodule
